// File: hdl/waf_pkg.sv
`default_nettype none

package waf_pkg;

   // longest word the length counter follows before it saturates
   localparam int MAX_WORD_LEN = 1024;
   localparam int LEN_CNT_W    = $clog2(MAX_WORD_LEN + 1);

   localparam int CFG_LEN_W    = 11;
   localparam int WORD_LEN_W   = 11;
   localparam int DROP_CNT_W   = 16;
   localparam int VERDICT_W    = 3;
   localparam int CHAR_W       = 8;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 64;
   localparam int TABLE_BITS   = 256;
   localparam int CMP_W        = (LEN_CNT_W > CFG_LEN_W) ? LEN_CNT_W : CFG_LEN_W;

   // bit 5 of a character: clear for capitals, forced on to look up the table
   localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

   localparam logic [CFG_LEN_W-1:0] MIN_LENGTH_RST = 11'd3;
   localparam logic [CFG_LEN_W-1:0] MAX_LENGTH_RST = 11'd100;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_LENGTH   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_LENGTH   = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ALLOW_NAMES  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ALLOW_ABBREV = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LETTERS_OK_0 = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_LETTERS_OK_1 = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_LETTERS_OK_2 = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_LETTERS_OK_3 = 4'd7;

   // verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_KEPT      = 3'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_TOO_SHORT = 3'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_TOO_LONG  = 3'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_ABBREV    = 3'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_NAME      = 3'd4;
   localparam logic [VERDICT_W-1:0] VERDICT_BAD_CHAR  = 3'd5;

   // action codes
   localparam logic ACTION_CHAR = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   typedef struct packed {
      logic              action;
      logic [CHAR_W-1:0] char_code;
   } req_type;

   typedef struct packed {
      logic [VERDICT_W-1:0]  verdict;
      logic [WORD_LEN_W-1:0] word_length;
      logic [DROP_CNT_W-1:0] short_drops;
      logic [DROP_CNT_W-1:0] long_drops;
   } rsp_type;

endpackage

`default_nettype wire

// File: hdl/word_admission_filter_unit.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_data  (action, char_code)
// rsp      out        rsp_valid / rsp_ready  rsp_data  (verdict, length, drop counts)
// csr      in         csr_we, no wait        csr_index, csr_wdata
//
// One transaction per cycle on req, unless an end-of-word waits on a stalled
// result. A transaction enters the input register; an end-of-word then lands
// in the result register, which drives rsp. Character transactions give no
// result. A stalled result only holds back the next end-of-word in the input
// register; characters keep flowing past it. Reset is synchronous and brings
// back the register defaults, cleared counters and an empty word.

module word_admission_filter_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire waf_pkg::req_type           req_data,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      waf_pkg::rsp_type           rsp_data,
   input  wire logic                       csr_we,
   input  wire logic [waf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [waf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import waf_pkg::*;

   // configuration registers
   logic [CFG_LEN_W-1:0]  min_length_ff;
   logic [CFG_LEN_W-1:0]  max_length_ff;
   logic                  allow_names_ff;
   logic                  allow_abbrev_ff;
   logic [TABLE_BITS-1:0] letters_ok_ff;

   // input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;

   // word state
   logic [LEN_CNT_W-1:0]  length_count_ff, length_count_in;
   logic                  all_capital_ff, all_capital_in;
   logic                  first_capital_ff, first_capital_in;
   logic                  all_allowed_ff, all_allowed_in;
   logic [DROP_CNT_W-1:0] short_total_ff, short_total_in;
   logic [DROP_CNT_W-1:0] long_total_ff, long_total_in;

   // result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                  advance;
   logic                  is_end;
   logic                  capital;
   logic                  allowed;
   logic [CHAR_W-1:0]     lookup_code;
   logic [CMP_W-1:0]      len_ext;
   logic                  too_short;
   logic                  too_long;
   logic [VERDICT_W-1:0]  verdict;

   //--------------------------------------------------------------------------
   // configuration writes; indexes past the list fall into the default arm
   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff   <= MIN_LENGTH_RST;
         max_length_ff   <= MAX_LENGTH_RST;
         allow_names_ff  <= 1'b1;
         allow_abbrev_ff <= 1'b0;
         letters_ok_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MIN_LENGTH:   min_length_ff   <= csr_wdata[CFG_LEN_W-1:0];
            REG_MAX_LENGTH:   max_length_ff   <= csr_wdata[CFG_LEN_W-1:0];
            REG_ALLOW_NAMES:  allow_names_ff  <= csr_wdata[0];
            REG_ALLOW_ABBREV: allow_abbrev_ff <= csr_wdata[0];
            REG_LETTERS_OK_0: letters_ok_ff[0*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
            REG_LETTERS_OK_1: letters_ok_ff[1*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
            REG_LETTERS_OK_2: letters_ok_ff[2*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
            REG_LETTERS_OK_3: letters_ok_ff[3*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   //--------------------------------------------------------------------------
   // handshake: the input stage moves on unless it holds an end-of-word and
   // the result register is still full
   assign is_end    = (in_item_ff.action == ACTION_END);
   assign advance   = in_valid_ff && (!is_end || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   //--------------------------------------------------------------------------
   // per-character tests and end-of-word verdict
   assign capital     = (in_item_ff.char_code & CASE_BIT) == '0;
   assign lookup_code = in_item_ff.char_code | CASE_BIT;
   assign allowed     = letters_ok_ff[lookup_code];

   assign len_ext   = CMP_W'(length_count_ff);
   assign too_short = len_ext < CMP_W'(min_length_ff);
   assign too_long  = len_ext > CMP_W'(max_length_ff);

   always_comb begin
      if (too_short) begin
         verdict = VERDICT_TOO_SHORT;
      end else if (too_long) begin
         verdict = VERDICT_TOO_LONG;
      end else if (!allow_abbrev_ff && all_capital_ff) begin
         verdict = VERDICT_ABBREV;
      end else if (!allow_names_ff && first_capital_ff) begin
         verdict = VERDICT_NAME;
      end else if (!all_allowed_ff) begin
         verdict = VERDICT_BAD_CHAR;
      end else begin
         verdict = VERDICT_KEPT;
      end
   end

   always_comb begin
      length_count_in  = length_count_ff;
      all_capital_in   = all_capital_ff;
      first_capital_in = first_capital_ff;
      all_allowed_in   = all_allowed_ff;
      short_total_in   = short_total_ff;
      long_total_in    = long_total_ff;
      if (advance) begin
         if (!is_end) begin
            if (length_count_ff == '0) begin
               first_capital_in = capital;
            end
            if (!capital) begin
               all_capital_in = 1'b0;
            end
            if (!allowed) begin
               all_allowed_in = 1'b0;
            end
            if (length_count_ff < LEN_CNT_W'(MAX_WORD_LEN)) begin
               length_count_in = length_count_ff + 1'b1;
            end
         end else begin
            // counters stick at full scale
            if (too_short) begin
               if (short_total_ff != '1) begin
                  short_total_in = short_total_ff + 1'b1;
               end
            end else if (too_long) begin
               if (long_total_ff != '1) begin
                  long_total_in = long_total_ff + 1'b1;
               end
            end
            length_count_in  = '0;
            all_capital_in   = 1'b1;
            first_capital_in = 1'b0;
            all_allowed_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_count_ff  <= '0;
         all_capital_ff   <= 1'b1;
         first_capital_ff <= 1'b0;
         all_allowed_ff   <= 1'b1;
         short_total_ff   <= '0;
         long_total_ff    <= '0;
      end else begin
         length_count_ff  <= length_count_in;
         all_capital_ff   <= all_capital_in;
         first_capital_ff <= first_capital_in;
         all_allowed_ff   <= all_allowed_in;
         short_total_ff   <= short_total_in;
         long_total_ff    <= long_total_in;
      end
   end

   //--------------------------------------------------------------------------
   // result register; drop counts include the word being closed
   always_comb begin
      rsp_data_in.verdict     = verdict;
      rsp_data_in.word_length = len_ext[WORD_LEN_W-1:0];
      rsp_data_in.short_drops = short_total_in;
      rsp_data_in.long_drops  = long_total_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance && is_end) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_end) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   //--------------------------------------------------------------------------
   // checks

   // an end-of-word leaves an empty word behind
   assert property (@(posedge clock) disable iff (reset)
      advance && is_end |=> length_count_ff == '0 && all_capital_ff && all_allowed_ff)
      else $error("word state not cleared after end of word");

   // a character always leaves a nonzero length
   assert property (@(posedge clock) disable iff (reset)
      advance && !is_end |=> length_count_ff != '0)
      else $error("length did not count a character");

   // length saturates at the maximum
   assert property (@(posedge clock) disable iff (reset)
      length_count_ff <= LEN_CNT_W'(MAX_WORD_LEN))
      else $error("length count beyond maximum");

   // drop counters never go backwards
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> short_total_ff >= $past(short_total_ff)
                        && long_total_ff >= $past(long_total_ff))
      else $error("drop counter decreased");

   // an end-of-word never overwrites a result that was not taken
   assert property (@(posedge clock) disable iff (reset)
      advance && is_end |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwritten");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import waf_pkg::*;

   // indexes past the last register; writes there must leave everything alone
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_FIRST = 4'd8;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_LAST  = 4'd15;

   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLD_AT_WORD  = 30;     // result count that starts the long rsp stall
   localparam int HOLD_CYCLES   = 400;
   localparam int REPORT_LIMIT  = 10;

   // ---------------------------------------------------------------------------
   // Clock, reset and DUT ports. Every input starts at a known value.
   // ---------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   always #2 clock = ~clock;

   word_admission_filter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Shared testbench state
   // ---------------------------------------------------------------------------
   req_type pending_reqs[$];      // transactions waiting for the driver
   rsp_type verdict_queue[$];     // verdicts predicted, oldest first

   int send_idle_pct = 32;
   int recv_idle_pct = 47;
   int results_seen  = 0;
   int error_count   = 0;

   // predictor's copy of the registers
   logic [CFG_LEN_W-1:0] cfg_min_len;
   logic [CFG_LEN_W-1:0] cfg_max_len;
   logic                 cfg_allow_names;
   logic                 cfg_allow_abbrev;
   logic [63:0]          cfg_letters[4];

   // predictor's copy of the word and drop-counter state
   logic [WORD_LEN_W-1:0] word_len;
   logic                  all_cap;
   logic                  first_cap;
   logic                  all_ok;
   logic [DROP_CNT_W-1:0] short_cnt;
   logic [DROP_CNT_W-1:0] long_cnt;

   function automatic void clear_word();
      word_len  = '0;
      all_cap   = 1'b1;
      first_cap = 1'b0;
      all_ok    = 1'b1;
   endfunction

   // Follow one accepted transaction; an end of word yields the expected verdict.
   function automatic void track_word(input req_type r);
      logic [CHAR_W-1:0] folded;
      logic              is_cap;
      rsp_type           res;
      if (r.action == ACTION_CHAR) begin
         is_cap = (r.char_code & CASE_BIT) == '0;
         if (word_len == '0) first_cap = is_cap;
         if (!is_cap) all_cap = 1'b0;
         // table lookup always uses the lower-case form
         folded = r.char_code | CASE_BIT;
         if (!cfg_letters[folded[7:6]][folded[5:0]]) all_ok = 1'b0;
         // length sticks at the max but flags keep updating
         if (word_len < MAX_WORD_LEN) word_len = word_len + 1'b1;
      end else begin
         // priority: short beats long even with min above max
         if (word_len < cfg_min_len) begin
            res.verdict = VERDICT_TOO_SHORT;
            if (short_cnt != '1) short_cnt = short_cnt + 1'b1;
         end else if (word_len > cfg_max_len) begin
            res.verdict = VERDICT_TOO_LONG;
            if (long_cnt != '1) long_cnt = long_cnt + 1'b1;
         end else if (!cfg_allow_abbrev && all_cap) begin
            res.verdict = VERDICT_ABBREV;   // empty word lands here too
         end else if (!cfg_allow_names && first_cap) begin
            res.verdict = VERDICT_NAME;
         end else if (!all_ok) begin
            res.verdict = VERDICT_BAD_CHAR;
         end else begin
            res.verdict = VERDICT_KEPT;
         end
         res.word_length = word_len;
         res.short_drops = short_cnt;
         res.long_drops  = long_cnt;
         verdict_queue.push_back(res);
         clear_word();
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: pops pending transactions, random gaps, holds payload until taken.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) track_word(req_data);
         // free to move on when idle or the current transaction just went in
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: random back-pressure plus one long stall, counted here, that
   // lets the block fill and push back on req.
   // ---------------------------------------------------------------------------
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen == HOLD_AT_WORD) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: every accepted result against the oldest prediction.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (verdict_queue.size() == 0) begin
            error_count = error_count + 1;
            if (error_count <= REPORT_LIMIT)
               $display("ERROR: unexpected result verdict=%0d len=%0d short=%0d long=%0d",
                        rsp_data.verdict, rsp_data.word_length,
                        rsp_data.short_drops, rsp_data.long_drops);
         end else begin
            want = verdict_queue.pop_front();
            if (rsp_data.verdict     !== want.verdict     ||
                rsp_data.word_length !== want.word_length ||
                rsp_data.short_drops !== want.short_drops ||
                rsp_data.long_drops  !== want.long_drops) begin
               error_count = error_count + 1;
               if (error_count <= REPORT_LIMIT)
                  $display({"ERROR: result %0d exp verdict=%0d len=%0d short=%0d long=%0d",
                            " got verdict=%0d len=%0d short=%0d long=%0d"},
                           results_seen, want.verdict, want.word_length,
                           want.short_drops, want.long_drops,
                           rsp_data.verdict, rsp_data.word_length,
                           rsp_data.short_drops, rsp_data.long_drops);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // One register write; the predictor copy changes together with the DUT's.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_MIN_LENGTH:   cfg_min_len      = data[CFG_LEN_W-1:0];
         REG_MAX_LENGTH:   cfg_max_len      = data[CFG_LEN_W-1:0];
         REG_ALLOW_NAMES:  cfg_allow_names  = data[0];
         REG_ALLOW_ABBREV: cfg_allow_abbrev = data[0];
         REG_LETTERS_OK_0: cfg_letters[0]   = data;
         REG_LETTERS_OK_1: cfg_letters[1]   = data;
         REG_LETTERS_OK_2: cfg_letters[2]   = data;
         REG_LETTERS_OK_3: cfg_letters[3]   = data;
         default: ;
      endcase
   endtask

   task automatic end_csr_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // junk in the upper bits; the block only keeps the register's width
   function automatic logic [63:0] with_junk(input logic [63:0] val, input int width);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      return (junk << width) | val;
   endfunction

   // Full register set for one phase.
   task automatic program_regs(input int min_len, input int max_len, input bit names,
                               input bit abbrev, input logic [63:0] t0, input logic [63:0] t1,
                               input logic [63:0] t2, input logic [63:0] t3);
      write_csr(REG_MIN_LENGTH,   with_junk(64'(min_len), CFG_LEN_W));
      write_csr(REG_MAX_LENGTH,   with_junk(64'(max_len), CFG_LEN_W));
      write_csr(REG_ALLOW_NAMES,  with_junk(64'(names), 1));
      write_csr(REG_ALLOW_ABBREV, with_junk(64'(abbrev), 1));
      write_csr(REG_LETTERS_OK_0, t0);
      write_csr(REG_LETTERS_OK_1, t1);
      write_csr(REG_LETTERS_OK_2, t2);
      write_csr(REG_LETTERS_OK_3, t3);
      end_csr_writes();
   endtask

   // Idle point: nothing queued, nothing on req, every verdict back, then a
   // drain wait for a trailing character still sitting in the input register.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || verdict_queue.size() != 0 || req_valid);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void push_char(input logic [CHAR_W-1:0] c);
      req_type r;
      r.action    = ACTION_CHAR;
      r.char_code = c;
      pending_reqs.push_back(r);
   endfunction

   // char_code of an end transaction is don't-care: randomize it
   function automatic void push_end();
      req_type r;
      r.action    = ACTION_END;
      r.char_code = CHAR_W'($urandom_range(255));
      pending_reqs.push_back(r);
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
      push_end();
   endfunction

   function automatic void push_run(input logic [CHAR_W-1:0] c, input int n);
      for (int i = 0; i < n; i++) push_char(c);
      push_end();
   endfunction

   function automatic logic [CHAR_W-1:0] pick_char();
      int sel;
      sel = $urandom_range(99);
      if (sel < 40)      return CHAR_W'("a" + $urandom_range(25));
      else if (sel < 65) return CHAR_W'("A" + $urandom_range(25));
      else               return CHAR_W'($urandom_range(255));
   endfunction

   // Mostly well-formed words with random content; some noise transactions
   // with random action, which also break words apart at odd places.
   function automatic void push_random(input int n);
      int count;
      int len;
      req_type r;
      count = 0;
      while (count < n) begin
         if ($urandom_range(99) < 15) begin
            r.action    = 1'($urandom_range(1));
            r.char_code = CHAR_W'($urandom_range(255));
            pending_reqs.push_back(r);
            count++;
         end else begin
            // short words dominate; some reach past the default max of 100
            if ($urandom_range(99) < 90) len = $urandom_range(10);
            else                         len = $urandom_range(130);
            // occasionally a word that is one style throughout
            case ($urandom_range(9))
               0: for (int i = 0; i < len; i++) push_char(CHAR_W'("A" + $urandom_range(25)));
               1: begin
                  if (len > 0) push_char(CHAR_W'("A" + $urandom_range(25)));
                  for (int i = 1; i < len; i++) push_char(CHAR_W'("a" + $urandom_range(25)));
               end
               default: for (int i = 0; i < len; i++) push_char(pick_char());
            endcase
            push_end();
            count += len + 1;
         end
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      logic [63:0] lower_az;

      // power-on defaults of the block
      cfg_min_len      = MIN_LENGTH_RST;
      cfg_max_len      = MAX_LENGTH_RST;
      cfg_allow_names  = 1'b1;
      cfg_allow_abbrev = 1'b0;
      foreach (cfg_letters[i]) cfg_letters[i] = '0;
      short_cnt = '0;
      long_cnt  = '0;
      clear_word();

      lower_az = '0;
      for (int c = "a"; c <= "z"; c++) lower_az[c - 64] = 1'b1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Phase 1: reset-like limits, only a..z allowed. Directed words.
      send_idle_pct = 32;
      recv_idle_pct = 47;
      program_regs(3, 100, 1'b1, 1'b0, 64'd0, lower_az, 64'd0, 64'd0);
      push_text("cat");                  // exactly min length, kept
      push_text("Cat");                  // name, names allowed
      push_text("CAT");                  // all capitals, abbreviations banned
      push_text("at");                   // too short
      push_text("ca1");                  // digit not in the table
      push_char(8'hFF);                  // byte extremes
      push_char(8'h00);
      push_text("a");
      push_end();                        // empty word, too short here
      push_text("zoo");
      wait_drained();

      // Phase 2: widest limits, names banned, random tables.
      program_regs(0, MAX_WORD_LEN, 1'b0, 1'b0, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
      push_end();                        // empty word with min 0 -> abbreviation
      push_text("Name");                 // capital first letter, names banned
      push_random(350);                  // the long rsp stall falls in here
      wait_drained();

      // Phase 3: swap idle rates; min above max, everything allowed by flags,
      // table all ones and all zeros.
      send_idle_pct = 47;
      recv_idle_pct = 32;
      program_regs(5, 2, 1'b1, 1'b1, '1, '0, '1, '0);
      push_random(400);
      wait_drained();

      // Phase 4: no idling; opposite extremes, plus writes to unused indexes.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_regs(MAX_WORD_LEN, 0, 1'b0, 1'b1, '0, '1, '0, '1);
      for (int i = 0; i < 4; i++)
         write_csr(CSR_INDEX_W'($urandom_range(REG_UNUSED_LAST, REG_UNUSED_FIRST)),
                   {$urandom, $urandom});
      end_csr_writes();
      push_run("Q", 12);                 // short of the largest minimum
      push_random(350);
      wait_drained();

      if (error_count == 0 && verdict_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
